/* rtl/i2c_master_status_sequencer_macros.svh */
// Assertion macros shared by the status sequencer modules.
`ifndef I2C_MASTER_STATUS_SEQUENCER_MACROS_SVH
`define I2C_MASTER_STATUS_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/i2cms_pkg.sv */
// Shared types and constants of the I2C master status sequencer.
package i2cms_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W       = 7;
  localparam int SLOT_W      = 6;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_W        = 32;
  localparam int OUT_W       = 40;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_LOAD   = 2'd1,
    OP_BEGIN  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRITE_COUNT = 2'd0,
    REG_READ_COUNT  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_STARTED   = 3'd1,
    PH_RESTART   = 3'd2,
    PH_DATA_ACK  = 3'd3,
    PH_DONE      = 3'd4,
    PH_ADDR_NACK = 3'd5
  } phase_t;

  // Controller status codes.
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;

  // Action record of one item before the transmit byte is merged in.
  typedef struct packed {
    logic              load;
    logic              tx_zero;
    logic              set_start;
    logic              set_stop;
    logic              set_ack;
    logic              clear_ack;
    logic              clear_start;
    logic              clear_int;
    phase_t            phase;
    logic              rx_valid;
    logic [SLOT_W-1:0] rx_slot;
    logic [BYTE_W-1:0] rx_byte;
  } action_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/i2cms_tx_store.sv */
// Transmit byte store: one write port and one registered read port.
module i2cms_tx_store (
  input  logic                            clk,
  input  logic                            en,
  input  i2cms_pkg::mem_req_t             req,
  output logic [i2cms_pkg::BYTE_W-1:0]    rdata_r
);

  logic [i2cms_pkg::BYTE_W-1:0] mem [i2cms_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[req.raddr];
    end
  end

endmodule

/* rtl/i2cms_ctrl.sv */
// Status decode, sequencer state and the first pipeline register.
`include "i2c_master_status_sequencer_macros.svh"

module i2cms_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              accept,
  input  logic [1:0]                        in_op,
  input  logic [7:0]                        in_code,
  input  logic [i2cms_pkg::BYTE_W-1:0]      in_rx,
  input  logic [i2cms_pkg::SLOT_W-1:0]      in_slot,
  input  logic [i2cms_pkg::BYTE_W-1:0]      in_byte,
  input  logic                              cfg_we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [i2cms_pkg::CNT_W-1:0]       cfg_val,
  output i2cms_pkg::mem_req_t               mem_req,
  output i2cms_pkg::action_t                act_r,
  output logic                              act_v_r
);

  localparam int CMP_W = i2cms_pkg::CNT_W + 2;
  localparam logic [i2cms_pkg::IDX_W-1:0] DEPTH_IDX = i2cms_pkg::IDX_W'(i2cms_pkg::STORE_DEPTH);

  logic [i2cms_pkg::IDX_W-1:0] wi_r, wi_nxt, wi_inc;
  logic [i2cms_pkg::IDX_W-1:0] ri_r, ri_nxt, ri_inc;
  i2cms_pkg::phase_t           phase_r, phase_nxt;
  logic [i2cms_pkg::CNT_W-1:0] wr_cnt_r, rd_cnt_r;
  i2cms_pkg::action_t          act;
  logic                        wi_below_cnt, ri_more, rd_cnt_one, wi_sat, ri_sat;

  assign wi_sat       = (wi_r >= DEPTH_IDX);
  assign ri_sat       = (ri_r >= DEPTH_IDX);
  assign wi_inc       = wi_sat ? DEPTH_IDX : wi_r + 1'b1;
  assign ri_inc       = ri_sat ? DEPTH_IDX : ri_r + 1'b1;
  assign wi_below_cnt = CMP_W'(wi_r) < CMP_W'(wr_cnt_r);
  // Compares the incremented read index plus one against the read count.
  assign ri_more      = (CMP_W'(ri_inc) + CMP_W'(1)) < CMP_W'(rd_cnt_r);
  assign rd_cnt_one   = (rd_cnt_r == i2cms_pkg::CNT_W'(1));

  always_comb begin
    act         = '0;
    act.phase   = phase_r;
    wi_nxt      = wi_r;
    ri_nxt      = ri_r;
    phase_nxt   = phase_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = i2cms_pkg::ADDR_W'(in_slot);
    mem_req.wdata = in_byte;
    mem_req.raddr = wi_r[i2cms_pkg::ADDR_W-1:0];

    case (i2cms_pkg::op_t'(in_op))
      i2cms_pkg::OP_LOAD: begin
        mem_req.we = accept;
      end
      i2cms_pkg::OP_BEGIN: begin
        phase_nxt = i2cms_pkg::PH_IDLE;
        wi_nxt    = '0;
        ri_nxt    = '0;
      end
      i2cms_pkg::OP_STATUS: begin
        case (in_code)
          i2cms_pkg::ST_START: begin
            mem_req.raddr   = '0;
            act.load        = 1'b1;
            act.set_ack     = 1'b1;
            act.clear_int   = 1'b1;
            act.clear_start = 1'b1;
            wi_nxt          = i2cms_pkg::IDX_W'(1);
            ri_nxt          = '0;
            phase_nxt       = i2cms_pkg::PH_STARTED;
          end
          i2cms_pkg::ST_RESTART: begin
            act.load        = 1'b1;
            act.tx_zero     = wi_sat;
            act.set_ack     = 1'b1;
            act.clear_int   = 1'b1;
            act.clear_start = 1'b1;
            ri_nxt          = '0;
            phase_nxt       = i2cms_pkg::PH_RESTART;
          end
          i2cms_pkg::ST_SLA_W_ACK: begin
            act.load      = 1'b1;
            act.tx_zero   = wi_sat;
            act.set_ack   = 1'b1;
            act.clear_int = 1'b1;
            wi_nxt        = wi_inc;
            phase_nxt     = i2cms_pkg::PH_DATA_ACK;
          end
          i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_NACK: begin
            act.set_stop  = 1'b1;
            act.set_ack   = 1'b1;
            act.clear_int = 1'b1;
            phase_nxt     = i2cms_pkg::PH_DONE;
          end
          i2cms_pkg::ST_DATA_ACK: begin
            if (wi_below_cnt) begin
              act.load      = 1'b1;
              act.tx_zero   = wi_sat;
              act.set_ack   = 1'b1;
              act.clear_int = 1'b1;
              wi_nxt        = wi_inc;
              phase_nxt     = i2cms_pkg::PH_DATA_ACK;
            end else if (rd_cnt_r != '0) begin
              act.set_start = 1'b1;
              act.clear_int = 1'b1;
            end else begin
              act.set_stop  = 1'b1;
              act.set_ack   = 1'b1;
              act.clear_int = 1'b1;
              phase_nxt     = i2cms_pkg::PH_DONE;
            end
          end
          i2cms_pkg::ST_ARB_LOST: begin
            act.set_start = 1'b1;
            act.set_ack   = 1'b1;
            act.clear_int = 1'b1;
            phase_nxt     = i2cms_pkg::PH_DONE;
          end
          i2cms_pkg::ST_SLA_R_ACK: begin
            act.clear_ack = rd_cnt_one;
            act.set_ack   = !rd_cnt_one;
            act.clear_int = 1'b1;
          end
          i2cms_pkg::ST_SLA_R_NACK: begin
            act.set_stop  = 1'b1;
            act.set_ack   = 1'b1;
            act.clear_int = 1'b1;
            phase_nxt     = i2cms_pkg::PH_ADDR_NACK;
          end
          i2cms_pkg::ST_RX_ACK: begin
            act.rx_valid  = !ri_sat;
            act.rx_slot   = ri_sat ? '0 : i2cms_pkg::SLOT_W'(ri_r);
            act.rx_byte   = ri_sat ? '0 : in_rx;
            act.clear_int = 1'b1;
            ri_nxt        = ri_inc;
            if (ri_more) begin
              act.set_ack = 1'b1;
              phase_nxt   = i2cms_pkg::PH_DATA_ACK;
            end else begin
              act.clear_ack = 1'b1;
              phase_nxt     = i2cms_pkg::PH_DONE;
            end
          end
          i2cms_pkg::ST_RX_NACK: begin
            act.rx_valid  = !ri_sat;
            act.rx_slot   = ri_sat ? '0 : i2cms_pkg::SLOT_W'(ri_r);
            act.rx_byte   = ri_sat ? '0 : in_rx;
            act.set_stop  = 1'b1;
            act.set_ack   = 1'b1;
            act.clear_int = 1'b1;
            phase_nxt     = i2cms_pkg::PH_DONE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    act.phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r     <= '0;
      ri_r     <= '0;
      phase_r  <= i2cms_pkg::PH_IDLE;
      wr_cnt_r <= '0;
      rd_cnt_r <= '0;
      act_v_r  <= 1'b0;
    end else begin
      if (accept) begin
        wi_r    <= wi_nxt;
        ri_r    <= ri_nxt;
        phase_r <= phase_nxt;
      end
      if (cfg_we && cfg_idx == i2cms_pkg::REG_WRITE_COUNT) begin
        wr_cnt_r <= cfg_val;
      end
      if (cfg_we && cfg_idx == i2cms_pkg::REG_READ_COUNT) begin
        rd_cnt_r <= cfg_val;
      end
      if (en) begin
        act_v_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act_r <= act;
    end
  end

  `I2CMS_ASSERT_NOW(a_idx_bound, 1'b1, (wi_r <= DEPTH_IDX) && (ri_r <= DEPTH_IDX), "index past store depth")
  `I2CMS_ASSERT_NEXT(a_begin_clear, accept && in_op == i2cms_pkg::OP_BEGIN, phase_r == i2cms_pkg::PH_IDLE && wi_r == '0 && ri_r == '0, "begin did not clear state")
  `I2CMS_ASSERT_NOW(a_ack_excl, act_v_r, !(act_r.set_ack && act_r.clear_ack), "set and clear ack together")

endmodule

/* rtl/i2c_master_status_sequencer.sv */
// I2C master status sequencer: turns controller status codes into action beats, one per
// input beat. Each action beat passes through the action register and then the output
// register; the extra stage is the registered read of the 64-byte transmit store, and the
// sustained rate is one beat per clock while the output side takes beats. Load beats fill the
// store, begin beats reset the phase and both indices, and status beats give the data byte,
// control strobes, new phase and any received byte with its slot. Configuration writes set
// the write and read byte counts and are accepted in any cycle outside reset.
`include "i2c_master_status_sequencer_macros.svh"

module i2c_master_status_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // operation[1:0], status_code[9:2], rx_data[17:10], tx_slot[23:18], tx_byte[31:24]
  input  logic [i2cms_pkg::IN_W-1:0]        in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // load_data[0], data_byte[8:1], set_start[9], set_stop[10], set_ack[11], clear_ack[12],
  // clear_start[13], clear_int[14], phase[17:15], rx_valid[18], rx_slot[24:19],
  // rx_byte[32:25], zero fill[39:33]
  output logic [i2cms_pkg::OUT_W-1:0]       out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cms_pkg::CNT_W-1:0]       cfg_data
);

  logic                          en, accept, act_v_r, out_valid_r;
  i2cms_pkg::action_t            act_r, out_r;
  i2cms_pkg::mem_req_t           mem_req;
  logic [i2cms_pkg::BYTE_W-1:0]  rdata_r, out_byte_r, byte_nxt;

  // The whole pipeline advances together whenever the output register is free or drained.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && rst_n;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  i2cms_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .accept  (accept),
    .in_op   (in_tdata[1:0]),
    .in_code (in_tdata[9:2]),
    .in_rx   (in_tdata[17:10]),
    .in_slot (in_tdata[23:18]),
    .in_byte (in_tdata[31:24]),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .mem_req (mem_req),
    .act_r   (act_r),
    .act_v_r (act_v_r)
  );

  i2cms_tx_store u_store (
    .clk     (clk),
    .en      (en),
    .req     (mem_req),
    .rdata_r (rdata_r)
  );

  assign byte_nxt = (act_r.load && !act_r.tx_zero) ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= act_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r      <= act_r;
      out_byte_r <= byte_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.rx_byte, out_r.rx_slot, out_r.rx_valid, out_r.phase,
                       out_r.clear_int, out_r.clear_start, out_r.clear_ack, out_r.set_ack,
                       out_r.set_stop, out_r.set_start, out_byte_r, out_r.load};

  `I2CMS_ASSERT_NEXT(a_accept_stage, accept, act_v_r, "accepted beat lost before output stage")
  `I2CMS_ASSERT_NOW(a_rx_no_load, out_valid_r && out_r.rx_valid, !out_r.load,
                    "receive beat also loads data")
  `I2CMS_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready,
                     out_valid_r && $stable(out_tdata), "waiting action beat changed")

endmodule
